/* rtl/itrt_pkg.sv */
// Shared types, constants and helper functions for the integer-to-text converter.
// Depends on nothing; used by itrt_divider, itrt_apb and integer_to_radix_text.
`default_nettype none

package itrt_pkg;

    localparam int DEF_MAX_CHARS  = 16;
    localparam int DEF_VALUE_BITS = 32;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int APB_DW  = 32;

    typedef logic [RADIX_W-1:0] radix_t;
    typedef logic [CHAR_W-1:0]  char_t;

    localparam radix_t RADIX_RESET = 6'd10;
    localparam radix_t RADIX_MIN   = 6'd2;
    localparam radix_t RADIX_MAX   = 6'd36;
    localparam radix_t RADIX_DEC   = 6'd10;
    localparam radix_t RADIX_HEX   = 6'd16;

    localparam char_t CHAR_ZERO  = 7'h30;
    localparam char_t CHAR_X     = 7'h78;
    localparam char_t CHAR_MINUS = 7'h2D;
    localparam char_t CHAR_A     = 7'h41;

    function automatic radix_t eff_radix(input radix_t r);
        radix_t res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic char_t digit_char(input radix_t d);
        char_t res;
        if (d < RADIX_DEC) begin
            res = CHAR_ZERO + char_t'(d);
        end else begin
            res = CHAR_A + char_t'(d - RADIX_DEC);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/itrt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module itrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/itrt_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
// Depends on itrt_pkg.
`default_nettype none

module itrt_divider #(
    parameter int VALUE_BITS = itrt_pkg::DEF_VALUE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_BITS-1:0]  dividend,
    input  itrt_pkg::radix_t       divisor,
    output logic                   done,
    output logic [VALUE_BITS-1:0]  quotient,
    output itrt_pkg::radix_t       remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    itrt_pkg::radix_t      rem_reg, rem_next;

    logic [itrt_pkg::RADIX_W:0] trial;
    logic                       ge;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], ge};
            rem_next = ge ? itrt_pkg::RADIX_W'(trial - {1'b0, divisor})
                          : itrt_pkg::RADIX_W'(trial);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("Divider started while a division was in progress.");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("Divider did not begin after start.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("Divider reported completion while still busy.");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor))
        else $error("Divider remainder is not below the divisor.");

endmodule

`default_nettype wire

/* rtl/itrt_apb.sv */
// APB-style configuration port holding the radix register.
// Depends on itrt_pkg.
`default_nettype none

module itrt_apb (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [itrt_pkg::APB_DW-1:0] pwdata,
    output logic [itrt_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output itrt_pkg::radix_t          radix
);

    itrt_pkg::radix_t radix_reg, radix_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && !paddr[2];

    always_comb
    begin
        radix_next = radix_reg;
        if (wr_en)
        begin
            radix_next = pwdata[itrt_pkg::RADIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itrt_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    assign prdata = paddr[2] ? '0
                             : {{(itrt_pkg::APB_DW - itrt_pkg::RADIX_W){1'b0}}, radix_reg};
    assign radix  = radix_reg;

endmodule

`default_nettype wire

/* rtl/integer_to_radix_text.sv */
// Top level of the integer-to-text converter: sequencer, digit buffer and output register.
// Depends on itrt_pkg, itrt_apb, itrt_divider and itrt_ram.
//
// A transaction is taken when start is high and busy is low; the text then appears one
// character per result_valid pulse, most significant first, with last_char on the final one.
// The receiver cannot stall, so every character is shown for exactly one cycle. A zero value
// gives its single character in the cycle after it is taken and busy stays low. Otherwise each
// digit costs one pass of the shared bit-serial divider, and each emitted character a further
// digit buffer read state (S_RD) before the output state (S_OUT). The radix is sampled when a
// transaction is taken.
`default_nettype none

module integer_to_radix_text #(
    parameter int MAX_CHARS  = itrt_pkg::DEF_MAX_CHARS,
    parameter int VALUE_BITS = itrt_pkg::DEF_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [itrt_pkg::APB_DW-1:0]   pwdata,
    output logic [itrt_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic                          result_valid,
    output logic [itrt_pkg::CHAR_W-1:0]   character,
    output logic                          last_char,
    output logic                          truncated
);

    localparam int ND_W  = $clog2(VALUE_BITS + 1);
    localparam int AW    = $clog2(VALUE_BITS);
    localparam int LEN_W = $clog2(VALUE_BITS + MAX_CHARS + 4);
    localparam int K_W   = $clog2(MAX_CHARS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIVGO = 3'd1;
    localparam logic [2:0] S_DIVWT = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]            state_reg, state_next;
    itrt_pkg::radix_t      base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic                  hex_reg, hex_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [ND_W-1:0]       nd_reg, nd_next;
    logic [AW-1:0]         dig_reg, dig_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [K_W-1:0]        count_reg, count_next;
    logic                  cut_reg, cut_next;
    logic [1:0]            pre_reg, pre_next;

    logic                  valid_reg, valid_next;
    itrt_pkg::char_t       char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  trunc_reg, trunc_next;

    itrt_pkg::radix_t      radix;
    itrt_pkg::radix_t      eff;
    logic [VALUE_BITS-1:0] uval;
    logic                  div_start;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    itrt_pkg::radix_t      div_rem;
    logic                  ram_we;
    itrt_pkg::char_t       ram_wdata;
    itrt_pkg::char_t       ram_rdata;
    logic [LEN_W-1:0]      len;
    logic [1:0]            pidx;
    itrt_pkg::char_t       pchar;
    logic                  is_last;

    itrt_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .radix   (radix)
    );

    itrt_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    itrt_ram #(
        .WIDTH (itrt_pkg::CHAR_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nd_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (dig_reg),
        .rdata (ram_rdata)
    );

    assign eff       = itrt_pkg::eff_radix(radix);
    assign uval      = $unsigned(value);
    assign div_start = (state_reg == S_DIVGO);
    assign ram_we    = (state_reg == S_DIVWT) && div_done;
    assign ram_wdata = itrt_pkg::digit_char(div_rem);
    assign len       = LEN_W'(nd_reg) + LEN_W'({hex_reg, neg_reg});
    assign pidx      = hex_reg ? k_reg[1:0] : k_reg[1:0] + 2'd2;
    assign is_last   = (k_reg + 1'b1) == count_reg;

    always_comb
    begin
        unique case (pidx)
            2'd0:    pchar = itrt_pkg::CHAR_ZERO;
            2'd1:    pchar = itrt_pkg::CHAR_X;
            default: pchar = itrt_pkg::CHAR_MINUS;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        hex_next   = hex_reg;
        mag_next   = mag_reg;
        nd_next    = nd_reg;
        dig_next   = dig_reg;
        k_next     = k_reg;
        count_next = count_reg;
        cut_next   = cut_reg;
        pre_next   = pre_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        trunc_next = trunc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    base_next = eff;
                    hex_next  = (eff == itrt_pkg::RADIX_HEX);
                    neg_next  = uval[VALUE_BITS-1];
                    mag_next  = uval[VALUE_BITS-1] ? VALUE_BITS'(~uval + 1'b1) : uval;
                    nd_next   = '0;
                    if (uval == '0)
                    begin
                        valid_next = 1'b1;
                        char_next  = itrt_pkg::CHAR_ZERO;
                        last_next  = 1'b1;
                        trunc_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_DIVGO;
                    end
                end
            end
            S_DIVGO:
            begin
                state_next = S_DIVWT;
            end
            S_DIVWT:
            begin
                if (div_done)
                begin
                    nd_next  = nd_reg + 1'b1;
                    mag_next = div_quo;
                    if (div_quo == '0)
                    begin
                        state_next = S_PREP;
                    end
                    else
                    begin
                        state_next = S_DIVGO;
                    end
                end
            end
            S_PREP:
            begin
                pre_next   = {hex_reg, 1'b0} + {1'b0, neg_reg};
                cut_next   = len > LEN_W'(MAX_CHARS);
                count_next = (len > LEN_W'(MAX_CHARS)) ? K_W'(MAX_CHARS) : K_W'(len);
                k_next     = '0;
                dig_next   = AW'(nd_reg - 1'b1);
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                valid_next = 1'b1;
                last_next  = is_last;
                trunc_next = cut_reg;
                if (k_reg < K_W'(pre_reg))
                begin
                    char_next = pchar;
                end
                else
                begin
                    char_next = ram_rdata;
                    dig_next  = dig_reg - 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (is_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            base_reg  <= itrt_pkg::RADIX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        hex_reg   <= hex_next;
        mag_reg   <= mag_next;
        nd_reg    <= nd_next;
        dig_reg   <= dig_next;
        k_reg     <= k_next;
        count_reg <= count_next;
        cut_reg   <= cut_next;
        pre_reg   <= pre_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        trunc_reg <= trunc_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign character    = char_reg;
    assign last_char    = last_reg;
    assign truncated    = trunc_reg;

endmodule

`default_nettype wire
